// ----- rtl/core/lennard_jones_force_accumulator_unit_macros.svh -----
// Assertion macros shared by the force accumulator RTL.
`ifndef LENNARD_JONES_FORCE_ACCUMULATOR_UNIT_MACROS_SVH
`define LENNARD_JONES_FORCE_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define LJFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ljfa assertion failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define LJFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ljfa assertion failed");

`endif

// ----- rtl/core/ljfa_pkg.sv -----
// Types, constants and clip helpers for the force accumulator.
package ljfa_pkg;

  localparam int unsigned MulW    = 48;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned HalfW   = MulW / 2;
  localparam int unsigned QuoW    = 48;
  localparam int unsigned D2W     = 50;
  localparam int unsigned ValW    = 47;
  localparam int unsigned AccW    = 48;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned RegW    = 32;
  localparam int unsigned CoefW   = 31;

  localparam logic [ValW-1:0] ValCap = {ValW{1'b1}};

  localparam logic [RegW-1:0]  CutoffReset = 32'd409600;
  localparam logic [RegW-1:0]  SigmaReset  = 32'd65536;
  localparam logic [CoefW-1:0] CoefReset   = 31'd1572864;

  typedef enum logic [1:0] {
    REG_CUTOFF_SQ  = 2'd0,
    REG_SIGMA_SQ   = 2'd1,
    REG_FORCE_COEF = 2'd2
  } ljfa_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_CHECK,
    ST_DIV,
    ST_POW,
    ST_GAIN,
    ST_FORCE,
    ST_FIN
  } ljfa_state_e;

  typedef struct packed {
    logic            clip;
    logic [ValW-1:0] val;
  } ljfa_clip_t;

  // Product shifted down by 16 and limited to 2^47-1.
  function automatic ljfa_clip_t clip_q16(input logic [ProdW-1:0] p);
    ljfa_clip_t r;
    r.clip = |p[ProdW-1:63];
    r.val  = r.clip ? ValCap : p[62:16];
    return r;
  endfunction

  // Product shifted down by 8 and limited to 2^47-1.
  function automatic ljfa_clip_t clip_q8(input logic [ProdW-1:0] p);
    ljfa_clip_t r;
    r.clip = |p[ProdW-1:55];
    r.val  = r.clip ? ValCap : p[54:8];
    return r;
  endfunction

endpackage

// ----- rtl/core/ljfa_mul.sv -----
// Shared 48x48 multiplier built from one 24x24 multiplier that forms the four partial products in turn.
module ljfa_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ljfa_pkg::MulW-1:0] a_i,
  input  logic [ljfa_pkg::MulW-1:0] b_i,
  output logic                      done_o,
  output logic [ljfa_pkg::ProdW-1:0] prod_o
);
  import ljfa_pkg::*;

  logic [MulW-1:0]  a_q, b_q;
  logic [ProdW-1:0] acc_q;
  logic [1:0]       cnt_q;
  logic             busy_q, done_q;
  logic [HalfW-1:0] a_part, b_part;
  logic [MulW-1:0]  pp;
  logic [ProdW-1:0] pp_sh;

  always_comb begin
    a_part = cnt_q[0] ? a_q[MulW-1:HalfW] : a_q[HalfW-1:0];
    b_part = cnt_q[1] ? b_q[MulW-1:HalfW] : b_q[HalfW-1:0];
    pp     = a_part * b_part;
    unique case (cnt_q)
      2'd0:    pp_sh = {{MulW{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {MulW{1'b0}}};
      default: pp_sh = {{HalfW{1'b0}}, pp, {HalfW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/core/ljfa_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ljfa_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ljfa_pkg::QuoW-1:0] num_i,
  input  logic [ljfa_pkg::D2W-1:0]  den_i,
  output logic                     done_o,
  output logic [ljfa_pkg::QuoW-1:0] quo_o
);
  import ljfa_pkg::*;

  localparam int unsigned CntW = $clog2(QuoW);

  logic [D2W-1:0]  den_q, rem_q;
  logic [QuoW-1:0] num_q, quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [D2W:0]    trial;
  logic            ge;

  always_comb begin
    trial = {rem_q, num_q[QuoW-1]};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The remainder stays below the divisor, so it fits the divisor width.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      num_q <= num_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], ge};
      rem_q <= ge ? D2W'(trial - {1'b0, den_q}) : trial[D2W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/core/lennard_jones_force_accumulator_unit.sv -----
// Lennard-Jones pair force accumulator: sequencer around a shared multiplier and a divider.
// A pair inside the cutoff runs three squares, a 48-step divide, four powers, one gain and
// three force products, each product on the one shared multiplier; a skipped pair stops after
// the squares. A new pair is taken only once the last one is through and the unit is idle.
// A last pair's word waits in the output register until taken; reset (rst_ni low, async)
// clears sums and flag and restores register defaults.
module lennard_jones_force_accumulator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x, center_y, center_z, neighbor_x, neighbor_y, neighbor_z (low bit up)
  input  logic [191:0] s_axis_tdata,
  // same_particle
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // force_x, force_y, force_z (low bit up)
  output logic [143:0] m_axis_tdata,
  // saturated
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import ljfa_pkg::*;

  `include "lennard_jones_force_accumulator_unit_macros.svh"

  ljfa_state_e state_q, state_d;

  logic [RegW-1:0]  cutoff_q, sigma_q;
  logic [CoefW-1:0] coef_q;

  logic signed [DiffW-1:0] r_q [3];
  logic                    same_q, last_q;
  logic [D2W-1:0]          d2_q;
  logic [1:0]              idx_q, idx_d;
  logic                    issued_q, issued_d;
  logic [ValW-1:0]         s_q, s2_q, s4_q, pw_q, g_q;
  logic                    uneg_q;
  logic signed [AccW-1:0]  acc_q [3];
  logic                    sat_q;
  logic [3*AccW-1:0]       out_data_q;
  logic                    out_sat_q;
  logic                    out_vld_q;

  logic                 mul_start, mul_done;
  logic [MulW-1:0]      mul_a, mul_b;
  logic [ProdW-1:0]     prod;
  logic                 div_start, div_done;
  logic [QuoW-1:0]      quo;

  logic [CoordW-1:0]     rmag;
  logic signed [ValW+1:0] u;
  logic [MulW-1:0]       umag;
  logic                  skip;
  ljfa_clip_t            c16, c8;
  logic [ValW+1:0]       cterm;
  logic signed [AccW:0]  sum;
  logic                  neg;
  logic                  fin_go;

  ljfa_mul u_mul (
    .clk_i, .rst_ni,
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  ljfa_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   ({sigma_q, 16'd0}),
    .den_i   (d2_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    rmag  = r_q[idx_q][DiffW-1] ? CoordW'(-r_q[idx_q]) : r_q[idx_q][CoordW-1:0];
    u     = $signed({1'b0, pw_q, 1'b0}) - $signed({2'b00, s4_q});
    umag  = u[ValW+1] ? MulW'(-u) : u[MulW-1:0];
    skip  = same_q || (d2_q > {{(D2W-RegW){1'b0}}, cutoff_q}) || (d2_q == '0);
    c16   = clip_q16(prod);
    c8    = clip_q8(prod);
    // Force points against u*r: the sign is negative when both signs agree.
    neg   = (uneg_q == r_q[idx_q][DiffW-1]);
    cterm = neg ? (ValW+2)'(-{2'b00, c8.val}) : {2'b00, c8.val};
    sum   = $signed({acc_q[idx_q][AccW-1], acc_q[idx_q]}) + $signed(cterm);
    // A last pair may hand over its word only once the output register is free.
    fin_go = !last_q || !out_vld_q || m_axis_tready;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    issued_d  = issued_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_a = {{(MulW-CoordW){1'b0}}, rmag};
        mul_b = {{(MulW-CoordW){1'b0}}, rmag};
      end
      ST_POW: begin
        unique case (idx_q)
          2'd0:    begin mul_a = {1'b0, s_q};  mul_b = {1'b0, s_q};  end
          2'd1:    begin mul_a = {1'b0, s2_q}; mul_b = {1'b0, s2_q}; end
          2'd2:    begin mul_a = {1'b0, s4_q}; mul_b = {1'b0, s2_q}; end
          default: begin mul_a = {1'b0, pw_q}; mul_b = {1'b0, s_q};  end
        endcase
      end
      ST_GAIN: begin
        mul_a = {{(MulW-CoefW){1'b0}}, coef_q};
        mul_b = umag;
      end
      ST_FORCE: begin
        mul_a = {1'b0, g_q};
        mul_b = {{(MulW-CoordW){1'b0}}, rmag};
      end
      default: ;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d  = ST_SQ;
          idx_d    = '0;
          issued_d = 1'b0;
        end
      end
      ST_SQ, ST_POW, ST_GAIN, ST_FORCE: begin
        mul_start = !issued_q;
        issued_d  = 1'b1;
        if (mul_done) begin
          issued_d = 1'b0;
          idx_d    = idx_q + 2'd1;
          priority if (state_q == ST_SQ && idx_q == 2'd2) begin
            state_d = ST_CHECK;
          end else if (state_q == ST_POW && idx_q == 2'd3) begin
            state_d = ST_GAIN;
            idx_d   = '0;
          end else if (state_q == ST_GAIN) begin
            state_d = ST_FORCE;
            idx_d   = '0;
          end else if (state_q == ST_FORCE && idx_q == 2'd2) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_CHECK: begin
        idx_d = '0;
        if (skip) begin
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_POW;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CutoffReset;
      sigma_q  <= SigmaReset;
      coef_q   <= CoefReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_CUTOFF_SQ)  cutoff_q <= cfg_data_i;
      if (cfg_idx_i == REG_SIGMA_SQ)   sigma_q  <= cfg_data_i;
      if (cfg_idx_i == REG_FORCE_COEF) coef_q   <= cfg_data_i[CoefW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
      sat_q    <= 1'b0;
    end else begin
      priority if (state_q == ST_POW && mul_done && c16.clip) begin
        sat_q <= 1'b1;
      end else if (state_q == ST_GAIN && mul_done && c16.clip) begin
        sat_q <= 1'b1;
      end else if (state_q == ST_DIV && div_done && quo[QuoW-1]) begin
        sat_q <= 1'b1;
      end else if (state_q == ST_FORCE && mul_done) begin
        if (c8.clip || (sum[AccW] != sum[AccW-1])) sat_q <= 1'b1;
        if (sum[AccW] != sum[AccW-1]) begin
          acc_q[idx_q] <= sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        end else begin
          acc_q[idx_q] <= sum[AccW-1:0];
        end
      end else if (state_q == ST_FIN && last_q && fin_go) begin
        acc_q[0] <= '0;
        acc_q[1] <= '0;
        acc_q[2] <= '0;
        sat_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_FIN && last_q && fin_go) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            r_q[i] <= $signed({s_axis_tdata[96+32*i+31], s_axis_tdata[96+32*i +: 32]})
                    - $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]});
          end
          same_q <= s_axis_tuser;
          last_q <= s_axis_tlast;
          d2_q   <= '0;
        end
      end
      ST_SQ: begin
        if (mul_done) d2_q <= d2_q + {2'b00, prod[63:16]};
      end
      ST_DIV: begin
        if (div_done) s_q <= quo[QuoW-1] ? ValCap : quo[ValW-1:0];
      end
      ST_POW: begin
        if (mul_done) begin
          unique case (idx_q)
            2'd0:    s2_q <= c16.val;
            2'd1:    s4_q <= c16.val;
            default: pw_q <= c16.val;
          endcase
        end
      end
      ST_GAIN: begin
        uneg_q <= u[ValW+1];
        if (mul_done) g_q <= c16.val;
      end
      ST_FIN: begin
        if (last_q && fin_go) begin
          out_data_q <= {acc_q[2], acc_q[1], acc_q[0]};
          out_sat_q  <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  `LJFA_ASSERT_NXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `LJFA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `LJFA_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV)
  `LJFA_ASSERT_IMP(a_mul_done_issued, mul_done, issued_q)

endmodule
